FILE: hw/rtl/tts_pkg.sv
// Timer table scheduler package: field widths, command and status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package tts_pkg;

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned ID_W        = 4;
  localparam int unsigned DELAY_W     = 24;
  localparam int unsigned PERIOD_W    = 24;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned DUE_W       = 33;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [TIME_W-1:0] NEVER = 32'h7fff_ffff;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_CREATE     = 3'd1,
    CMD_RENEW      = 3'd2,
    CMD_CANCEL     = 3'd3,
    CMD_CANCEL_ALL = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_EXPIRY = 1'b1
  } kind_e;

  typedef struct packed {
    logic ready;
    logic act;
    logic scan_start;
    logic crt_write;
    logic upd;
    logic emit_held;
    logic emit_final;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic scan_done;
    logic pick_go;
    logic held;
    logic is_tick;
    logic is_create;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hw/rtl/tts_in_if.sv
// Input channel of the timer table scheduler: valid/ready and one command beat.
// Depends on tts_pkg.
interface tts_in_if;
  import tts_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [ID_W-1:0]     timer_id;
  logic [DELAY_W-1:0]  delay;
  logic                never;
  logic [PERIOD_W-1:0] period;

  modport source (output valid, cmd, timer_id, delay, never, period, input ready);
  modport sink   (input valid, cmd, timer_id, delay, never, period, output ready);
endinterface

FILE: hw/rtl/tts_out_if.sv
// Result channel of the timer table scheduler: valid/ready and one result beat.
// Depends on tts_pkg.
interface tts_out_if;
  import tts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [ID_W-1:0]         event_id;
  logic [STATUS_W-1:0]     status;
  logic signed [DUE_W-1:0] next_due;
  logic                    last;

  modport source (output valid, kind, event_id, status, next_due, last, input ready);
  modport sink   (input valid, kind, event_id, status, next_due, last, output ready);
endinterface

FILE: hw/rtl/tts_ctrl.sv
// Timer table scheduler controller: sequences command action, slot scans,
// expiry service and result beats. Depends on tts_pkg.
module tts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tts_pkg::dp_sts_t sts_i,
  output tts_pkg::dp_cmd_t cmd_o
);
  import tts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACT,
    S_START,
    S_WAIT,
    S_EMIT_EV,
    S_UPD,
    S_CRT,
    S_FINAL
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.ready = 1'b1;
        if (sts_i.in_valid) state_d = S_ACT;
      end
      S_ACT: begin
        cmd_o.act = 1'b1;
        state_d   = S_START;
      end
      S_START: begin
        cmd_o.scan_start = 1'b1;
        state_d          = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.scan_done) begin
          if (sts_i.is_tick && sts_i.pick_go) begin
            state_d = sts_i.held ? S_EMIT_EV : S_UPD;
          end else if (sts_i.is_create) begin
            state_d = S_CRT;
          end else begin
            state_d = S_FINAL;
          end
        end
      end
      S_EMIT_EV: begin
        if (sts_i.out_free) begin
          cmd_o.emit_held = 1'b1;
          state_d         = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_START;
      end
      S_CRT: begin
        cmd_o.crt_write = 1'b1;
        state_d         = S_FINAL;
      end
      S_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/tts_dp.sv
// Timer table scheduler datapath: slot tables, time counter, sequential slot
// scanner and output register. Depends on tts_pkg, tts_in_if and tts_out_if.
module tts_dp #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tts_in_if.sink           in_i,
  tts_out_if.source        out_o,
  input  tts_pkg::dp_cmd_t cmd_i,
  output tts_pkg::dp_sts_t sts_o
);
  import tts_pkg::*;

  localparam int unsigned     IW       = $clog2(NUM_TIMERS);
  localparam logic [IW-1:0]   LAST_IDX = IW'(NUM_TIMERS - 1);

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0]   base,
                                                input logic [PERIOD_W-1:0] add);
    logic [TIME_W:0] sum;
    sum = {1'b0, base} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, add};
    return (sum >= {1'b0, NEVER}) ? NEVER : sum[TIME_W-1:0];
  endfunction

  logic                accept;
  logic [CMD_W-1:0]    cmd_q;
  logic [ID_W-1:0]     id_q;
  logic [DELAY_W-1:0]  delay_q;
  logic                nev_q;
  logic [PERIOD_W-1:0] per_q;
  cmd_e                cmd_code;

  logic [TIME_W-1:0]     now_q;
  logic [NUM_TIMERS-1:0] valid_q;
  logic [CNT_W-1:0]      count_q;
  logic                  held_q;
  logic [IW-1:0]         held_idx_q;
  logic                  id_ok_q;

  logic [TIME_W-1:0]   deadline_mem [NUM_TIMERS];
  logic [PERIOD_W-1:0] period_mem   [NUM_TIMERS];
  logic [TIME_W-1:0]   dl_rd_q;
  logic [PERIOD_W-1:0] per_rd_q;

  logic          scan_run_q;
  logic [IW-1:0] scan_addr_q;
  logic          cmp_vld_q;
  logic          cmp_last_q;
  logic [IW-1:0] cmp_idx_q;
  logic          cmp_v_q;
  logic          scan_done_q;

  logic                pick_found_q;
  logic [IW-1:0]       pick_idx_q;
  logic [TIME_W-1:0]   pick_dl_q;
  logic [PERIOD_W-1:0] pick_per_q;
  logic                any_q;
  logic [TIME_W-1:0]   min_q;
  logic                free_found_q;
  logic [IW-1:0]       free_idx_q;

  logic [IW-1:0]       id_idx;
  logic                id_ok;
  logic [TIME_W-1:0]   new_dl;
  logic [TIME_W-1:0]   upd_dl;
  logic                dl_we;
  logic                per_we;
  logic [IW-1:0]       mem_addr;
  logic [TIME_W-1:0]   mem_dl;

  logic signed [DUE_W-1:0] due;
  logic [ID_W-1:0]         fin_id;
  status_e                 fin_st;

  logic                    out_valid_q;
  kind_e                   kind_q;
  logic [ID_W-1:0]         event_id_q;
  status_e                 status_q;
  logic signed [DUE_W-1:0] next_due_q;
  logic                    last_q;

  assign in_i.ready = cmd_i.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign cmd_code   = cmd_e'(cmd_q);
  assign id_idx     = IW'(id_q);
  assign id_ok      = (32'(id_q) < NUM_TIMERS) && valid_q[id_idx];
  assign new_dl     = nev_q ? NEVER : sat_add(now_q, delay_q);
  assign upd_dl     = sat_add(now_q, pick_per_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_i.cmd;
      id_q    <= in_i.timer_id;
      delay_q <= in_i.delay;
      nev_q   <= in_i.never;
      per_q   <= in_i.period;
    end
    if (cmd_i.act) id_ok_q <= id_ok;
    if (cmd_i.upd) held_idx_q <= pick_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= '0;
      valid_q <= '0;
      count_q <= '0;
      held_q  <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= '0;
        held_q  <= 1'b0;
      end
      if (cmd_i.act) begin
        unique case (cmd_code)
          CMD_TICK:       if (now_q < NEVER) now_q <= now_q + 1'b1;
          CMD_CANCEL:     if (id_ok) valid_q[id_idx] <= 1'b0;
          CMD_CANCEL_ALL: valid_q <= '0;
          default: ;
        endcase
      end
      if (cmd_i.crt_write && free_found_q) valid_q[free_idx_q] <= 1'b1;
      if (cmd_i.upd) begin
        count_q <= count_q + 1'b1;
        held_q  <= 1'b1;
        if (pick_per_q == '0) valid_q[pick_idx_q] <= 1'b0;
      end
    end
  end

  always_comb begin
    mem_addr = id_idx;
    mem_dl   = new_dl;
    dl_we    = 1'b0;
    per_we   = 1'b0;
    if (cmd_i.act && (cmd_code == CMD_RENEW) && id_ok) begin
      dl_we  = 1'b1;
      per_we = 1'b1;
    end
    if (cmd_i.crt_write && free_found_q) begin
      mem_addr = free_idx_q;
      dl_we    = 1'b1;
      per_we   = 1'b1;
    end
    if (cmd_i.upd && (pick_per_q != '0)) begin
      mem_addr = pick_idx_q;
      mem_dl   = upd_dl;
      dl_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) deadline_mem[mem_addr] <= mem_dl;
    if (per_we) period_mem[mem_addr] <= per_q;
    dl_rd_q  <= deadline_mem[scan_addr_q];
    per_rd_q <= period_mem[scan_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_run_q  <= 1'b0;
      scan_addr_q <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_last_q  <= 1'b0;
      scan_done_q <= 1'b0;
    end else begin
      cmp_vld_q   <= scan_run_q;
      cmp_last_q  <= (scan_addr_q == LAST_IDX);
      scan_done_q <= cmp_vld_q && cmp_last_q;
      if (cmd_i.scan_start) begin
        scan_run_q  <= 1'b1;
        scan_addr_q <= '0;
      end else if (scan_run_q) begin
        if (scan_addr_q == LAST_IDX) begin
          scan_run_q <= 1'b0;
        end else begin
          scan_addr_q <= scan_addr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= scan_addr_q;
    cmp_v_q   <= valid_q[scan_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_found_q <= 1'b0;
      any_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      pick_found_q <= 1'b0;
      any_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmp_vld_q) begin
      if (cmp_v_q && (dl_rd_q != NEVER) && (dl_rd_q <= now_q) &&
          (!pick_found_q || (dl_rd_q < pick_dl_q))) begin
        pick_found_q <= 1'b1;
        pick_idx_q   <= cmp_idx_q;
        pick_dl_q    <= dl_rd_q;
        pick_per_q   <= per_rd_q;
      end
      if (cmp_v_q && (!any_q || (dl_rd_q < min_q))) begin
        any_q <= 1'b1;
        min_q <= dl_rd_q;
      end
      if (!cmp_v_q && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= cmp_idx_q;
      end
    end else if (cmd_i.crt_write && free_found_q && (!any_q || (new_dl < min_q))) begin
      any_q <= 1'b1;
      min_q <= new_dl;
    end
  end

  always_comb begin
    if (!any_q) begin
      due = '1;
    end else if (min_q <= now_q) begin
      due = '0;
    end else begin
      due = {1'b0, min_q - now_q};
    end
  end

  always_comb begin
    fin_id = '0;
    fin_st = ST_OK;
    unique case (cmd_code)
      CMD_CREATE: begin
        if (free_found_q) begin
          fin_id = ID_W'(free_idx_q);
        end else begin
          fin_st = ST_FULL;
        end
      end
      CMD_RENEW, CMD_CANCEL: begin
        fin_id = id_q;
        fin_st = id_ok_q ? ST_OK : ST_NOT_FOUND;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_held || cmd_i.emit_final) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_held) begin
      kind_q     <= KIND_EXPIRY;
      event_id_q <= ID_W'(held_idx_q);
      status_q   <= ST_OK;
      next_due_q <= '0;
      last_q     <= 1'b0;
    end else if (cmd_i.emit_final) begin
      kind_q     <= held_q ? KIND_EXPIRY : KIND_STATUS;
      event_id_q <= held_q ? ID_W'(held_idx_q) : fin_id;
      status_q   <= held_q ? ST_OK : fin_st;
      next_due_q <= due;
      last_q     <= 1'b1;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.kind     = kind_q;
  assign out_o.event_id = event_id_q;
  assign out_o.status   = status_q;
  assign out_o.next_due = next_due_q;
  assign out_o.last     = last_q;

  assign sts_o.in_valid  = in_i.valid;
  assign sts_o.scan_done = scan_done_q;
  assign sts_o.pick_go   = pick_found_q && (count_q < CNT_W'(MAX_RESULTS));
  assign sts_o.held      = held_q;
  assign sts_o.is_tick   = (cmd_code == CMD_TICK);
  assign sts_o.is_create = (cmd_code == CMD_CREATE);
  assign sts_o.out_free  = !out_valid_q || out_o.ready;

  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done_q |-> !scan_run_q && !cmp_vld_q)
    else $error("scan done while scanner still busy");

  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_held || cmd_i.emit_final) |-> sts_o.out_free)
    else $error("result beat loaded over an untaken beat");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RESULTS))
    else $error("expiry count beyond limit");

  a_held_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> (cmd_code == CMD_TICK))
    else $error("expiry event held for a non-tick command");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !scan_run_q && !cmp_vld_q && !cmd_i.upd)
    else $error("command accepted during a scan");

endmodule

FILE: hw/rtl/timer_table_scheduler_unit.sv
// Timer table scheduler top level. Each command runs one slot scan, and a create
// then writes a free slot if one is found. A tick runs a further scan after each
// expiry it serves, up to 16 per tick. A result beat that waits on the receiver
// stalls the block. One item in flight at a time. Reset clears the time counter, the
// slot valid bits and the handshake state; the slot memories are not cleared and are
// read only when valid.
module timer_table_scheduler_unit #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tts_in_if.sink    in_i,
  tts_out_if.source out_o
);
  import tts_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  tts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (dp_sts),
    .cmd_o  (dp_cmd)
  );

  tts_dp #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (dp_cmd),
    .sts_o  (dp_sts)
  );

endmodule

FILE: tb/timer_table_scheduler_unit_checker.sv
// Checker for the timer table scheduler: watches the command and result channels,
// predicts every result beat from its own copy of the timer table and compares.
// Depends on tts_pkg, tts_in_if and tts_out_if.
module timer_table_scheduler_unit_checker #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tts_in_if           in_i,
  tts_out_if          out_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);
  import tts_pkg::*;

  typedef struct packed {
    kind_e               kind;
    logic [ID_W-1:0]     id;
    status_e             status;
    logic [DUE_W-1:0]    due;
    logic                last;
  } result_beat_t;

  logic                armed    [NUM_TIMERS];
  logic [TIME_W-1:0]   deadline [NUM_TIMERS];
  logic [PERIOD_W-1:0] interval [NUM_TIMERS];
  logic [TIME_W-1:0]   now_q;
  result_beat_t        pending_beats[$];
  int unsigned         errs;

  function automatic logic [TIME_W-1:0] sat_deadline(logic [TIME_W-1:0] base,
                                                     logic [DELAY_W-1:0] add);
    logic [TIME_W:0] sum;
    sum = {1'b0, base} + {{(TIME_W + 1 - DELAY_W){1'b0}}, add};
    return (sum >= {1'b0, NEVER}) ? NEVER : sum[TIME_W-1:0];
  endfunction

  function automatic logic [DUE_W-1:0] time_to_next();
    logic              found;
    logic [TIME_W-1:0] best;
    found = 1'b0;
    best  = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (armed[i] && (!found || deadline[i] < best)) begin
        best  = deadline[i];
        found = 1'b1;
      end
    end
    if (!found) return '1;
    if (best <= now_q) return '0;
    return DUE_W'(best - now_q);
  endfunction

  function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                        logic [DELAY_W-1:0] delay, logic no_expiry,
                                        logic [PERIOD_W-1:0] period);
    logic [TIME_W-1:0] dl;
    int                pick;
    int                slot;
    int                n;
    result_beat_t      b;
    dl = no_expiry ? NEVER : sat_deadline(now_q, delay);
    case (cmd)
      CMD_TICK: begin
        n = 0;
        if (now_q < NEVER) now_q = now_q + 1;
        while (n < MAX_RESULTS) begin
          pick = -1;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (armed[i] && deadline[i] != NEVER && deadline[i] <= now_q &&
                (pick < 0 || deadline[i] < deadline[pick]))
              pick = i;
          end
          if (pick < 0) break;
          if (interval[pick] > 0) deadline[pick] = sat_deadline(now_q, interval[pick]);
          else armed[pick] = 1'b0;
          pending_beats.push_back('{KIND_EXPIRY, ID_W'(pick), ST_OK, '0, 1'b0});
          n++;
        end
        if (n == 0) begin
          pending_beats.push_back('{KIND_STATUS, '0, ST_OK, time_to_next(), 1'b1});
        end else begin
          b = pending_beats.pop_back();
          b.due  = time_to_next();
          b.last = 1'b1;
          pending_beats.push_back(b);
        end
      end
      CMD_CREATE: begin
        slot = -1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (!armed[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          pending_beats.push_back('{KIND_STATUS, '0, ST_FULL, time_to_next(), 1'b1});
        end else begin
          armed[slot]    = 1'b1;
          deadline[slot] = dl;
          interval[slot] = period;
          pending_beats.push_back('{KIND_STATUS, ID_W'(slot), ST_OK, time_to_next(), 1'b1});
        end
      end
      CMD_RENEW, CMD_CANCEL: begin
        if (32'(id) >= NUM_TIMERS || !armed[id]) begin
          pending_beats.push_back('{KIND_STATUS, id, ST_NOT_FOUND, time_to_next(), 1'b1});
        end else begin
          if (cmd == CMD_RENEW) begin
            deadline[id] = dl;
            interval[id] = period;
          end else begin
            armed[id] = 1'b0;
          end
          pending_beats.push_back('{KIND_STATUS, id, ST_OK, time_to_next(), 1'b1});
        end
      end
      CMD_CANCEL_ALL: begin
        for (int i = 0; i < NUM_TIMERS; i++) armed[i] = 1'b0;
        pending_beats.push_back('{KIND_STATUS, '0, ST_OK, time_to_next(), 1'b1});
      end
      default: begin
        pending_beats.push_back('{KIND_STATUS, '0, ST_OK, time_to_next(), 1'b1});
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_beat_t want;
    result_beat_t seen;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        armed[i]    = 1'b0;
        deadline[i] = '0;
        interval[i] = '0;
      end
      now_q = '0;
      pending_beats.delete();
      errs = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_i.valid && in_i.ready)
        apply_command(in_i.cmd, in_i.timer_id, in_i.delay, in_i.never, in_i.period);
      if (out_i.valid && out_i.ready) begin
        seen = '{kind_e'(out_i.kind), out_i.event_id, status_e'(out_i.status),
                 out_i.next_due, out_i.last};
        if (pending_beats.size() == 0) begin
          $display("%0t: unexpected result beat kind=%0d id=%0d status=%0d next_due=%0d last=%0d",
                   $time, seen.kind, seen.id, seen.status, $signed(seen.due), seen.last);
          errs++;
        end else begin
          want = pending_beats.pop_front();
          if (seen !== want) begin
            $display("%0t: result mismatch: expected kind=%0d id=%0d status=%0d next_due=%0d last=%0d",
                     $time, want.kind, want.id, want.status, $signed(want.due), want.last);
            $display("%0t:                  actual kind=%0d id=%0d status=%0d next_due=%0d last=%0d",
                     $time, seen.kind, seen.id, seen.status, $signed(seen.due), seen.last);
            errs++;
          end
        end
      end
      err_cnt_o <= errs;
      pending_o <= pending_beats.size();
    end
  end

endmodule

FILE: tb/timer_table_scheduler_unit_tb.sv
// Testbench top for the timer table scheduler: clock, reset, command stimulus and
// result back-pressure, with the checker beside the block giving the verdict.
// Depends on tts_pkg, tts_in_if, tts_out_if, timer_table_scheduler_unit and timer_table_scheduler_unit_checker.
module timer_table_scheduler_unit_tb;
  import tts_pkg::*;

  localparam int unsigned NUM_TIMERS = 16;
  localparam int unsigned LIMIT      = 1_000_000;
  localparam int unsigned PHASE_LEN  = 67;

  logic        clk;
  logic        rst_n;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned err_cnt;
  int unsigned pending;
  int unsigned cycles;

  tts_in_if  cmd_if ();
  tts_out_if res_if ();

  timer_table_scheduler_unit #(
    .NUM_TIMERS(NUM_TIMERS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  timer_table_scheduler_unit_checker #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_checker (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_i     (cmd_if),
    .out_i    (res_if),
    .err_cnt_o(err_cnt),
    .pending_o(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    res_if.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timer_table_scheduler_unit test failed");
      $finish;
    end
  end

  task automatic send(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                      input logic [DELAY_W-1:0] delay, input logic no_expiry,
                      input logic [PERIOD_W-1:0] period);
    while ($urandom_range(99) < idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.cmd      <= cmd;
    cmd_if.timer_id <= id;
    cmd_if.delay    <= delay;
    cmd_if.never    <= no_expiry;
    cmd_if.period   <= period;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // Mostly short delays and periods so that timers keep expiring.
  task automatic send_random();
    int unsigned         pick;
    logic [CMD_W-1:0]    cmd;
    logic [DELAY_W-1:0]  delay;
    logic [PERIOD_W-1:0] period;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) delay = DELAY_W'($urandom());
    else delay = DELAY_W'($urandom_range(6));
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7, 8: period = '0;
      17, 18, 19: period = PERIOD_W'($urandom());
      default: period = PERIOD_W'($urandom_range(5, 1));
    endcase
    if (pick < 38) cmd = CMD_TICK;
    else if (pick < 68) cmd = CMD_CREATE;
    else if (pick < 80) cmd = CMD_RENEW;
    else if (pick < 91) cmd = CMD_CANCEL;
    else if (pick < 94) cmd = CMD_CANCEL_ALL;
    else cmd = CMD_W'($urandom_range(2**CMD_W - 1, int'(CMD_CANCEL_ALL) + 1));
    send(cmd, ID_W'($urandom_range(2**ID_W - 1)), delay, ($urandom_range(9) == 0), period);
  endtask

  initial begin
    rst_n           = 1'b0;
    idle_pct        = 15;
    stall_pct       = 73;
    cmd_if.valid    = 1'b0;
    cmd_if.cmd      = CMD_TICK;
    cmd_if.timer_id = '0;
    cmd_if.delay    = '0;
    cmd_if.never    = 1'b0;
    cmd_if.period   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(CMD_TICK, '0, '0, 1'b0, '0);
    send(CMD_CANCEL, '1, '0, 1'b0, '0);
    send(CMD_RENEW, ID_W'(5), '1, 1'b1, '1);
    for (int c = int'(CMD_CANCEL_ALL) + 1; c < 2**CMD_W; c++)
      send(CMD_W'(c), '1, '1, 1'b1, '1);
    send(CMD_CREATE, '0, '1, 1'b1, '1);
    send(CMD_CREATE, '0, DELAY_W'(1), 1'b0, PERIOD_W'(1));
    for (int i = 2; i < NUM_TIMERS; i++)
      send(CMD_CREATE, ID_W'(i), DELAY_W'(2), 1'b0, '0);
    send(CMD_CREATE, '0, DELAY_W'(2), 1'b0, '0);
    send(CMD_TICK, '0, '0, 1'b0, '0);
    send(CMD_TICK, '0, '0, 1'b0, '0);
    send(CMD_RENEW, '0, '0, 1'b0, '0);
    send(CMD_CANCEL, ID_W'(1), '0, 1'b0, '0);
    send(CMD_TICK, '0, '0, 1'b0, '0);
    send(CMD_CANCEL_ALL, '0, '0, 1'b0, '0);

    repeat (PHASE_LEN) send_random();
    idle_pct  = 73;
    stall_pct = 15;
    repeat (PHASE_LEN) send_random();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (PHASE_LEN) send_random();

    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * NUM_TIMERS + 8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("timer_table_scheduler_unit test passed");
    end else begin
      $display("timer_table_scheduler_unit test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tts_pkg.sv
hw/rtl/tts_in_if.sv
hw/rtl/tts_out_if.sv
hw/rtl/tts_ctrl.sv
hw/rtl/tts_dp.sv
hw/rtl/timer_table_scheduler_unit.sv
tb/timer_table_scheduler_unit_checker.sv
tb/timer_table_scheduler_unit_tb.sv
